// ===== rtl/sstf_pkg.sv =====
package sstf_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int TAG_W    = 8;
    localparam int SECTOR_W = 48;
    localparam int LEN_W    = 16;
    localparam int ENTRY_W  = TAG_W + SECTOR_W + LEN_W;

    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [5:0]       FULL_COUNT6 = 6'(QUEUE_DEPTH);

    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_DISPATCH = 2'd1;
    localparam logic [1:0] CMD_REMOVE   = 2'd2;

    typedef logic [1:0] op_t;
    localparam op_t OP_ADD      = 2'd0;
    localparam op_t OP_DISPATCH = 2'd1;
    localparam op_t OP_REMOVE   = 2'd2;
    localparam op_t OP_NONE     = 2'd3;

    localparam logic [2:0] ST_ADDED      = 3'd0;
    localparam logic [2:0] ST_DISPATCHED = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_EMPTY      = 3'd3;
    localparam logic [2:0] ST_REMOVED    = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd5;

    typedef struct packed {
        op_t                 op;
        logic [TAG_W-1:0]    tag;
        logic [SECTOR_W-1:0] sector;
        logic [LEN_W-1:0]    length;
    } req_t;

endpackage

// ===== rtl/sstf_ram.sv =====
module sstf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/sstf_front.sv =====
module sstf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [sstf_pkg::TAG_W-1:0]    request_tag,
    input  logic [sstf_pkg::SECTOR_W-1:0] request_sector,
    input  logic [sstf_pkg::LEN_W-1:0]    request_length,
    output logic                          q_valid,
    output sstf_pkg::req_t                q_req,
    input  logic                          q_pop
);

    sstf_pkg::req_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     fill_reg;
    logic           push;
    sstf_pkg::req_t decoded;

    always_comb
    begin
        decoded.tag    = request_tag;
        decoded.sector = request_sector;
        decoded.length = request_length;
        unique case (command)
            sstf_pkg::CMD_ADD:      decoded.op = sstf_pkg::OP_ADD;
            sstf_pkg::CMD_DISPATCH: decoded.op = sstf_pkg::OP_DISPATCH;
            sstf_pkg::CMD_REMOVE:   decoded.op = sstf_pkg::OP_REMOVE;
            default:                decoded.op = sstf_pkg::OP_NONE;
        endcase
    end

    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_req    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (q_pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ===== rtl/sstf_back.sv =====
module sstf_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  sstf_pkg::req_t                q_req,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic [sstf_pkg::TAG_W-1:0]    out_tag,
    output logic [sstf_pkg::SECTOR_W-1:0] out_sector,
    output logic [sstf_pkg::LEN_W-1:0]    out_length,
    output logic [5:0]                    pending_count
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]                      state_reg;
    sstf_pkg::req_t                  cur_reg;
    logic [sstf_pkg::IDX_W-1:0]      scan_idx_reg;
    logic [sstf_pkg::SECTOR_W-1:0]   head_reg;
    logic [sstf_pkg::QUEUE_DEPTH-1:0] valid_reg;
    logic [sstf_pkg::CNT_W-1:0]      count_reg;

    // stage A: RAM data for a_idx_reg
    logic                            a_vld_reg;
    logic [sstf_pkg::IDX_W-1:0]      a_idx_reg;
    // stage B: distance and match flags, compared against the best so far
    logic                            b_vld_reg;
    logic [sstf_pkg::IDX_W-1:0]      b_idx_reg;
    logic                            b_live_reg;
    logic                            b_tag_hit_reg;
    logic [sstf_pkg::SECTOR_W-1:0]   b_dist_reg;
    logic [sstf_pkg::SECTOR_W-1:0]   b_start_reg;
    logic [sstf_pkg::TAG_W-1:0]      b_tag_reg;
    logic [sstf_pkg::LEN_W-1:0]      b_len_reg;

    logic                            best_found_reg;
    logic [sstf_pkg::IDX_W-1:0]      best_idx_reg;
    logic [sstf_pkg::SECTOR_W-1:0]   best_dist_reg;
    logic [sstf_pkg::SECTOR_W-1:0]   best_start_reg;
    logic [sstf_pkg::TAG_W-1:0]      best_tag_reg;
    logic [sstf_pkg::LEN_W-1:0]      best_len_reg;

    logic                            out_valid_reg;
    logic [2:0]                      status_reg;
    logic [sstf_pkg::TAG_W-1:0]      out_tag_reg;
    logic [sstf_pkg::SECTOR_W-1:0]   out_sector_reg;
    logic [sstf_pkg::LEN_W-1:0]      out_length_reg;
    logic [5:0]                      pending_reg;

    logic [sstf_pkg::ENTRY_W-1:0]    rdata;
    logic [sstf_pkg::ENTRY_W-1:0]    wdata;
    logic                            ram_we;
    logic [sstf_pkg::TAG_W-1:0]      e_tag;
    logic [sstf_pkg::SECTOR_W-1:0]   e_start;
    logic [sstf_pkg::SECTOR_W:0]     diff_fwd;
    logic [sstf_pkg::SECTOR_W:0]     diff_rev;
    logic [sstf_pkg::SECTOR_W-1:0]   a_dist;
    logic                            take;
    logic                            finish_go;
    logic [sstf_pkg::SECTOR_W:0]     end_sum;
    logic [sstf_pkg::SECTOR_W-1:0]   head_next;
    logic [2:0]                      status_next;
    logic [sstf_pkg::CNT_W-1:0]      count_next;
    logic [sstf_pkg::CNT_W+5:0]      count_ext;

    sstf_ram #(
        .WIDTH (sstf_pkg::ENTRY_W),
        .DEPTH (sstf_pkg::QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (best_idx_reg),
        .wdata (wdata),
        .raddr (scan_idx_reg),
        .rdata (rdata)
    );

    assign e_tag   = rdata[sstf_pkg::ENTRY_W-1 -: sstf_pkg::TAG_W];
    assign e_start = rdata[sstf_pkg::LEN_W +: sstf_pkg::SECTOR_W];
    assign wdata   = {cur_reg.tag, cur_reg.sector, cur_reg.length};

    assign diff_fwd = {1'b0, e_start} - {1'b0, head_reg};
    assign diff_rev = {1'b0, head_reg} - {1'b0, e_start};
    assign a_dist   = diff_fwd[sstf_pkg::SECTOR_W] ? diff_rev[sstf_pkg::SECTOR_W-1:0]
                                                   : diff_fwd[sstf_pkg::SECTOR_W-1:0];

    always_comb
    begin
        unique case (cur_reg.op)
            sstf_pkg::OP_ADD:
                take = !b_live_reg && !best_found_reg;
            sstf_pkg::OP_DISPATCH:
                take = b_live_reg && (!best_found_reg || b_dist_reg < best_dist_reg ||
                       (b_dist_reg == best_dist_reg && b_start_reg > best_start_reg));
            sstf_pkg::OP_REMOVE:
                take = b_live_reg && b_tag_hit_reg && !best_found_reg;
            default:
                take = 1'b0;
        endcase
    end

    assign finish_go = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign ram_we    = finish_go && (cur_reg.op == sstf_pkg::OP_ADD) && best_found_reg;

    // head moves to the end sector, saturating at the top of the sector range
    assign end_sum   = {1'b0, best_start_reg} + (sstf_pkg::SECTOR_W + 1)'(best_len_reg);
    assign head_next = end_sum[sstf_pkg::SECTOR_W] ? '1 : end_sum[sstf_pkg::SECTOR_W-1:0];

    always_comb
    begin
        count_next = count_reg;
        unique case (cur_reg.op)
            sstf_pkg::OP_ADD:
            begin
                status_next = best_found_reg ? sstf_pkg::ST_ADDED : sstf_pkg::ST_FULL;
                if (best_found_reg)
                begin
                    count_next = count_reg + sstf_pkg::CNT_W'(1);
                end
            end
            sstf_pkg::OP_DISPATCH:
            begin
                status_next = best_found_reg ? sstf_pkg::ST_DISPATCHED : sstf_pkg::ST_EMPTY;
                if (best_found_reg)
                begin
                    count_next = count_reg - sstf_pkg::CNT_W'(1);
                end
            end
            sstf_pkg::OP_REMOVE:
            begin
                status_next = best_found_reg ? sstf_pkg::ST_REMOVED : sstf_pkg::ST_NOT_FOUND;
                if (best_found_reg)
                begin
                    count_next = count_reg - sstf_pkg::CNT_W'(1);
                end
            end
            default:
                status_next = sstf_pkg::ST_NOT_FOUND;
        endcase
    end

    assign count_ext = {6'd0, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_idx_reg   <= '0;
            a_vld_reg      <= 1'b0;
            b_vld_reg      <= 1'b0;
            best_found_reg <= 1'b0;
            head_reg       <= '0;
            valid_reg      <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            a_vld_reg     <= (state_reg == S_SCAN);
            b_vld_reg     <= a_vld_reg;
            out_valid_reg <= finish_go || (out_valid_reg && out_stall);
            if (b_vld_reg && take)
            begin
                best_found_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        scan_idx_reg   <= '0;
                        best_found_reg <= 1'b0;
                        state_reg      <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (scan_idx_reg == sstf_pkg::LAST_IDX)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + sstf_pkg::IDX_W'(1);
                    end
                end
                S_DRAIN:
                begin
                    if (!a_vld_reg && !b_vld_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (finish_go)
                    begin
                        count_reg <= count_next;
                        state_reg <= S_IDLE;
                        if (best_found_reg)
                        begin
                            unique case (cur_reg.op)
                                sstf_pkg::OP_ADD:
                                    valid_reg[best_idx_reg] <= 1'b1;
                                sstf_pkg::OP_DISPATCH:
                                begin
                                    valid_reg[best_idx_reg] <= 1'b0;
                                    head_reg                <= head_next;
                                end
                                sstf_pkg::OP_REMOVE:
                                    valid_reg[best_idx_reg] <= 1'b0;
                                default:
                                    valid_reg <= valid_reg;
                            endcase
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_req;
        end
        a_idx_reg     <= scan_idx_reg;
        b_idx_reg     <= a_idx_reg;
        b_live_reg    <= valid_reg[a_idx_reg];
        b_tag_hit_reg <= (e_tag == cur_reg.tag);
        b_dist_reg    <= a_dist;
        b_start_reg   <= e_start;
        b_tag_reg     <= e_tag;
        b_len_reg     <= rdata[sstf_pkg::LEN_W-1:0];
        if (b_vld_reg && take)
        begin
            best_idx_reg   <= b_idx_reg;
            best_dist_reg  <= b_dist_reg;
            best_start_reg <= b_start_reg;
            best_tag_reg   <= b_tag_reg;
            best_len_reg   <= b_len_reg;
        end
        if (finish_go)
        begin
            status_reg  <= status_next;
            pending_reg <= count_ext[5:0];
            if (status_next == sstf_pkg::ST_DISPATCHED)
            begin
                out_tag_reg    <= best_tag_reg;
                out_sector_reg <= best_start_reg;
                out_length_reg <= best_len_reg;
            end
            else
            begin
                out_tag_reg    <= '0;
                out_sector_reg <= '0;
                out_length_reg <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign out_tag       = out_tag_reg;
    assign out_sector    = out_sector_reg;
    assign out_length    = out_length_reg;
    assign pending_count = pending_reg;

endmodule

// ===== rtl/sstf_request_scheduler_core.sv =====
// Channel | Handshake          | Fields
// input   | in_valid, in_stall | command, request_tag, request_sector, request_length
// output  | out_valid, out_stall | status, out_tag, out_sector, out_length, pending_count
//
// Every command passes through the back end in turn: the idle state pops the queue, the
// table RAM is scanned one entry per cycle through its single read port, the drain state
// empties the read and compare stages, then the finish state commits.
// A two-entry queue takes transfers while the back end is busy.
// Reset clears the valid bits, the count and the head at once; no clearing pass.
// in_stall rises only when the queue is full; a stalled result holds the back end.
module sstf_request_scheduler_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [sstf_pkg::TAG_W-1:0]    request_tag,
    input  logic [sstf_pkg::SECTOR_W-1:0] request_sector,
    input  logic [sstf_pkg::LEN_W-1:0]    request_length,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic [sstf_pkg::TAG_W-1:0]    out_tag,
    output logic [sstf_pkg::SECTOR_W-1:0] out_sector,
    output logic [sstf_pkg::LEN_W-1:0]    out_length,
    output logic [5:0]                    pending_count
);

    logic           q_valid;
    logic           q_pop;
    sstf_pkg::req_t q_req;

    sstf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .request_tag    (request_tag),
        .request_sector (request_sector),
        .request_length (request_length),
        .q_valid        (q_valid),
        .q_req          (q_req),
        .q_pop          (q_pop)
    );

    sstf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_req         (q_req),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .out_tag       (out_tag),
        .out_sector    (out_sector),
        .out_length    (out_length),
        .pending_count (pending_count)
    );

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != sstf_pkg::ST_DISPATCHED |->
        out_tag == '0 && out_sector == '0 && out_length == '0)
        else $error("non-dispatch result carries request fields");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == sstf_pkg::ST_EMPTY |-> pending_count == 6'd0)
        else $error("empty reported with pending requests");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == sstf_pkg::ST_FULL |-> pending_count == sstf_pkg::FULL_COUNT6)
        else $error("full reported below capacity");

endmodule

// ===== test/tb_sstf_request_scheduler_core.sv =====
`timescale 1ns / 1ps

typedef struct {
    logic [2:0]                    status;
    logic [sstf_pkg::TAG_W-1:0]    tag;
    logic [sstf_pkg::SECTOR_W-1:0] sector;
    logic [sstf_pkg::LEN_W-1:0]    length;
    logic [5:0]                    count;
} sched_result_t;

class sstf_scoreboard;
    bit                            slot_valid [sstf_pkg::QUEUE_DEPTH];
    logic [sstf_pkg::TAG_W-1:0]    slot_tag   [sstf_pkg::QUEUE_DEPTH];
    logic [sstf_pkg::SECTOR_W-1:0] slot_start [sstf_pkg::QUEUE_DEPTH];
    logic [sstf_pkg::LEN_W-1:0]    slot_len   [sstf_pkg::QUEUE_DEPTH];
    logic [sstf_pkg::SECTOR_W-1:0] head;
    sched_result_t                 expected_q [$];
    int                            errors;

    function new();
        foreach (slot_valid[i]) begin
            slot_valid[i] = 0;
            slot_tag[i]   = '0;
            slot_start[i] = '0;
            slot_len[i]   = '0;
        end
        head   = '0;
        errors = 0;
    endfunction

    function int pending();
        int n;
        n = 0;
        foreach (slot_valid[i])
            if (slot_valid[i])
                n++;
        return n;
    endfunction

    // apply one accepted request to the table and queue the expected response
    function void note_request(logic [1:0] cmd, logic [sstf_pkg::TAG_W-1:0] t,
                               logic [sstf_pkg::SECTOR_W-1:0] s,
                               logic [sstf_pkg::LEN_W-1:0] l);
        sched_result_t                 r;
        int                            best;
        logic [sstf_pkg::SECTOR_W-1:0] d, best_d;
        logic [sstf_pkg::SECTOR_W:0]   end_sec;
        r.status = sstf_pkg::ST_NOT_FOUND;
        r.tag    = '0;
        r.sector = '0;
        r.length = '0;
        best     = -1;
        best_d   = '0;
        if (cmd == sstf_pkg::CMD_ADD) begin
            r.status = sstf_pkg::ST_FULL;
            for (int i = 0; i < sstf_pkg::QUEUE_DEPTH; i++) begin
                if (!slot_valid[i]) begin
                    slot_valid[i] = 1;
                    slot_tag[i]   = t;
                    slot_start[i] = s;
                    slot_len[i]   = l;
                    r.status      = sstf_pkg::ST_ADDED;
                    break;
                end
            end
        end else if (cmd == sstf_pkg::CMD_DISPATCH) begin
            for (int i = 0; i < sstf_pkg::QUEUE_DEPTH; i++) begin
                if (slot_valid[i]) begin
                    d = (slot_start[i] > head) ? slot_start[i] - head : head - slot_start[i];
                    if (best < 0 || d < best_d ||
                        (d == best_d && slot_start[i] > slot_start[best])) begin
                        best   = i;
                        best_d = d;
                    end
                end
            end
            if (best < 0) begin
                r.status = sstf_pkg::ST_EMPTY;
            end else begin
                end_sec = {1'b0, slot_start[best]} + (sstf_pkg::SECTOR_W + 1)'(slot_len[best]);
                head    = end_sec[sstf_pkg::SECTOR_W] ? '1 : end_sec[sstf_pkg::SECTOR_W-1:0];
                slot_valid[best] = 0;
                r.status = sstf_pkg::ST_DISPATCHED;
                r.tag    = slot_tag[best];
                r.sector = slot_start[best];
                r.length = slot_len[best];
            end
        end else if (cmd == sstf_pkg::CMD_REMOVE) begin
            for (int i = 0; i < sstf_pkg::QUEUE_DEPTH; i++) begin
                if (slot_valid[i] && slot_tag[i] == t) begin
                    slot_valid[i] = 0;
                    r.status      = sstf_pkg::ST_REMOVED;
                    break;
                end
            end
        end
        r.count = 6'(pending());
        expected_q.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
        sched_result_t e;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected response status=%0d", $time, got.status);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (got.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
            errors++;
        end
        if (got.tag !== e.tag) begin
            $display("%0t: out_tag exp %0h got %0h", $time, e.tag, got.tag);
            errors++;
        end
        if (got.sector !== e.sector) begin
            $display("%0t: out_sector exp %0h got %0h", $time, e.sector, got.sector);
            errors++;
        end
        if (got.length !== e.length) begin
            $display("%0t: out_length exp %0h got %0h", $time, e.length, got.length);
            errors++;
        end
        if (got.count !== e.count) begin
            $display("%0t: pending_count exp %0d got %0d", $time, e.count, got.count);
            errors++;
        end
    endfunction
endclass

module tb_sstf_request_scheduler_core;

    localparam logic [sstf_pkg::SECTOR_W-1:0] MAX_SECTOR = '1;

    logic                          clk = 0;
    logic                          rst_n = 0;
    logic                          in_valid = 0;
    logic                          in_stall;
    logic [1:0]                    command = sstf_pkg::CMD_ADD;
    logic [sstf_pkg::TAG_W-1:0]    request_tag = '0;
    logic [sstf_pkg::SECTOR_W-1:0] request_sector = '0;
    logic [sstf_pkg::LEN_W-1:0]    request_length = 1;
    logic                          out_valid;
    logic                          out_stall = 0;
    logic [2:0]                    status;
    logic [sstf_pkg::TAG_W-1:0]    out_tag;
    logic [sstf_pkg::SECTOR_W-1:0] out_sector;
    logic [sstf_pkg::LEN_W-1:0]    out_length;
    logic [5:0]                    pending_count;

    sstf_scoreboard sb = new();
    int  sender_idle_pct = 0;
    int  recv_stall_pct  = 0;
    int  hold_cycles     = 0;
    int  add_pct         = 50;

    always #2 clk = ~clk;

    sstf_request_scheduler_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .request_tag    (request_tag),
        .request_sector (request_sector),
        .request_length (request_length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .out_tag        (out_tag),
        .out_sector     (out_sector),
        .out_length     (out_length),
        .pending_count  (pending_count)
    );

    task automatic send_request(logic [1:0] cmd, logic [sstf_pkg::TAG_W-1:0] t,
                                logic [sstf_pkg::SECTOR_W-1:0] s,
                                logic [sstf_pkg::LEN_W-1:0] l);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge clk);
            in_valid = 0;
        end
        @(negedge clk);
        in_valid       = 1;
        command        = cmd;
        request_tag    = t;
        request_sector = s;
        request_length = l;
        forever begin
            @(posedge clk);
            if (!in_stall) begin
                sb.note_request(cmd, t, s, l);
                break;
            end
        end
    endtask

    task automatic idle_until_drained();
        @(negedge clk);
        in_valid = 0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_request();
        logic [1:0]                    cmd;
        logic [sstf_pkg::TAG_W-1:0]    t;
        logic [sstf_pkg::SECTOR_W-1:0] s;
        logic [sstf_pkg::LEN_W-1:0]    l;
        int                            r, pick;
        logic [sstf_pkg::SECTOR_W-1:0] offset;
        r = $urandom_range(0, 99);
        if (r < add_pct)
            cmd = sstf_pkg::CMD_ADD;
        else if (r < add_pct + (100 - add_pct) * 3 / 4)
            cmd = sstf_pkg::CMD_DISPATCH;
        else
            cmd = sstf_pkg::CMD_REMOVE;
        t = ($urandom_range(0, 1) == 0) ? sstf_pkg::TAG_W'($urandom_range(0, 15))
                                        : sstf_pkg::TAG_W'($urandom);
        if (cmd == sstf_pkg::CMD_REMOVE && sb.pending() > 0 && $urandom_range(0, 9) < 7) begin
            pick = $urandom_range(0, sstf_pkg::QUEUE_DEPTH - 1);
            while (!sb.slot_valid[pick])
                pick = (pick + 1) % sstf_pkg::QUEUE_DEPTH;
            t = sb.slot_tag[pick];
        end
        offset = sstf_pkg::SECTOR_W'($urandom_range(0, 64));
        case ($urandom_range(0, 5))
            0: s = sstf_pkg::SECTOR_W'({$urandom, $urandom});
            1: s = sb.head + offset;
            2: s = sb.head - offset;
            3: s = MAX_SECTOR - offset;
            4: s = offset;
            default: s = ($urandom_range(0, 1) == 0) ? sb.head + sstf_pkg::SECTOR_W'(8)
                                                     : sb.head - sstf_pkg::SECTOR_W'(8);
        endcase
        case ($urandom_range(0, 3))
            0: l = sstf_pkg::LEN_W'(1);
            1: l = '1;
            2: l = sstf_pkg::LEN_W'($urandom_range(1, 16));
            default: l = sstf_pkg::LEN_W'($urandom_range(1, 65535));
        endcase
        send_request(cmd, t, s, l);
    endtask

    // response side: random stall, plus one long hold-off on request
    initial begin
        sched_result_t got;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                out_stall = 1;
                hold_cycles--;
            end else begin
                out_stall = ($urandom_range(0, 99) < recv_stall_pct);
            end
            @(posedge clk);
            if (out_valid && !out_stall) begin
                got.status = status;
                got.tag    = out_tag;
                got.sector = out_sector;
                got.length = out_length;
                got.count  = pending_count;
                sb.check_result(got);
            end
        end
    end

    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty, missing tag, extremes, tie-break, duplicates, saturation
        send_request(sstf_pkg::CMD_DISPATCH, 0, 0, 1);
        send_request(sstf_pkg::CMD_REMOVE, 5, 0, 1);
        send_request(sstf_pkg::CMD_ADD, 0, 0, 1);
        send_request(sstf_pkg::CMD_ADD, 8'hff, MAX_SECTOR, '1);
        send_request(sstf_pkg::CMD_DISPATCH, 0, 0, 1);
        send_request(sstf_pkg::CMD_DISPATCH, 0, 0, 1);
        send_request(sstf_pkg::CMD_ADD, 3, 1000, 10);
        send_request(sstf_pkg::CMD_DISPATCH, 0, 0, 1);
        send_request(sstf_pkg::CMD_ADD, 4, 1005, 3);
        send_request(sstf_pkg::CMD_ADD, 5, 1015, 7);
        send_request(sstf_pkg::CMD_DISPATCH, 0, 0, 1);
        send_request(sstf_pkg::CMD_ADD, 6, 1030, 2);
        send_request(sstf_pkg::CMD_ADD, 7, 1030, 4);
        send_request(sstf_pkg::CMD_ADD, 6, 1014, 1);
        send_request(sstf_pkg::CMD_DISPATCH, 0, 0, 1);
        send_request(sstf_pkg::CMD_REMOVE, 6, 0, 1);
        send_request(sstf_pkg::CMD_REMOVE, 6, 0, 1);
        send_request(sstf_pkg::CMD_REMOVE, 6, 0, 1);
        send_request(sstf_pkg::CMD_DISPATCH, 0, 0, 1);
        send_request(sstf_pkg::CMD_DISPATCH, 0, 0, 1);
        send_request(sstf_pkg::CMD_DISPATCH, 0, 0, 1);
        idle_until_drained();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin sender_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            add_pct = (phase % 3 == 0) ? 75 : ((phase % 3 == 1) ? 30 : 50);
            if (phase == 4)
                hold_cycles = 500;
            for (int n = 0; n < 141; n++)
                random_request();
            // sender waits here until every response is back
            idle_until_drained();
        end

        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
